// ----- hw/rtl/pksvm_pkg.sv -----
// Shared types and constants for the polynomial-kernel SVM classifier.
// Used by pksvm_mul, pksvm_sv_mem and the top level; no dependencies.
package pksvm_pkg;

  localparam int DEF_MAX_VECTORS = 256;
  localparam int DEF_POLY_DEGREE = 3;
  localparam int DEF_FRAC_BITS   = 16;

  localparam int W_VAL   = 40;   // feature, dot, kernel and power values
  localparam int W_SUM   = 48;   // weighted terms and decision sum
  localparam int W_IN    = 39;   // unsigned measurement inputs
  localparam int W_IDX   = 8;    // slot index on the input beat
  localparam int W_CNT   = 9;    // vectors in use
  localparam int W_PROD  = 2 * W_VAL;
  localparam int W_HALF  = W_VAL / 2;
  localparam int W_REGI  = 3;

  localparam logic KIND_LOAD     = 1'b0;
  localparam logic KIND_CLASSIFY = 1'b1;

  localparam logic [W_REGI-1:0] REG_GAIN       = 3'd0;
  localparam logic [W_REGI-1:0] REG_DQDS_MEAN  = 3'd1;
  localparam logic [W_REGI-1:0] REG_LEN_MEAN   = 3'd2;
  localparam logic [W_REGI-1:0] REG_DQDS_INV   = 3'd3;
  localparam logic [W_REGI-1:0] REG_LEN_INV    = 3'd4;
  localparam logic [W_REGI-1:0] REG_GAMMA      = 3'd5;
  localparam logic [W_REGI-1:0] REG_OFFSET     = 3'd6;
  localparam logic [W_REGI-1:0] REG_RHO        = 3'd7;

  typedef struct packed {
    logic              start;
    logic              wide;   // saturate to W_SUM instead of W_VAL
    logic [W_VAL-1:0]  a;
    logic [W_VAL-1:0]  b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [W_SUM-1:0]  res;
  } mul_rsp_t;

  function automatic logic signed [W_SUM-1:0] sx_val(input logic [W_VAL-1:0] v);
    sx_val = {{(W_SUM - W_VAL){v[W_VAL-1]}}, v};
  endfunction

endpackage

// ----- hw/rtl/pksvm_mul.sv -----
// Shared multi-cycle fixed-point multiplier: 20x20 partial products, floor
// rounding and saturation. Depends on pksvm_pkg.
module pksvm_mul import pksvm_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam logic [2:0] STEP_ROUND = 3'd4;
  localparam logic [2:0] STEP_SAT   = 3'd5;

  logic              busy;
  logic [2:0]        step;
  logic              neg;
  logic              wide;
  logic [W_VAL-1:0]  ma;
  logic [W_VAL-1:0]  mb;
  logic [W_PROD-1:0] prod;
  logic [W_PROD-1:0] qr;
  logic              done;
  logic              sat;
  logic [W_SUM-1:0]  res;

  logic [W_HALF-1:0] ha, hb;
  logic [W_VAL-1:0]  pp;
  logic [W_PROD-1:0] pp_sh;
  logic [W_PROD-1:0] q;
  logic              rem;
  logic [W_PROD-1:0] lim;
  logic [W_PROD-1:0] qs;
  logic              over;

  always_comb begin
    ha = step[1] ? ma[W_VAL-1:W_HALF] : ma[W_HALF-1:0];
    hb = step[0] ? mb[W_VAL-1:W_HALF] : mb[W_HALF-1:0];
    pp = ha * hb;
    case (step[1:0])
      2'd0:    pp_sh = W_PROD'(pp);
      2'd3:    pp_sh = W_PROD'(pp) << (2 * W_HALF);
      default: pp_sh = W_PROD'(pp) << W_HALF;
    endcase
    q   = prod >> FRAC_BITS;
    rem = |prod[FRAC_BITS-1:0];
    lim = wide ? (W_PROD'(1) << (W_SUM - 1)) : (W_PROD'(1) << (W_VAL - 1));
    if (!neg) lim = lim - W_PROD'(1);
    over = qr > lim;
    qs   = over ? lim : qr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        neg  <= req.a[W_VAL-1] ^ req.b[W_VAL-1];
        wide <= req.wide;
        ma   <= req.a[W_VAL-1] ? W_VAL'(-req.a) : req.a;
        mb   <= req.b[W_VAL-1] ? W_VAL'(-req.b) : req.b;
        prod <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step < STEP_ROUND) begin
          prod <= prod + pp_sh;
        end else if (step == STEP_ROUND) begin
          qr <= q + W_PROD'(neg && rem);
        end else begin
          sat  <= over;
          res  <= neg ? W_SUM'(-qs[W_SUM-1:0]) : qs[W_SUM-1:0];
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.sat  = sat;
  assign rsp.res  = res;

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("multiplier restarted while busy");
  a_done_after_sat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(step) == STEP_SAT) else $error("done without final step");

endmodule

// ----- hw/rtl/pksvm_sv_mem.sv -----
// Support vector store: weight and both coordinates in one wide word,
// one write port and one registered read port. Depends on pksvm_pkg.
module pksvm_sv_mem import pksvm_pkg::*; #(
  parameter int DEPTH = DEF_MAX_VECTORS,
  parameter int AW    = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [3*W_VAL-1:0]   wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [3*W_VAL-1:0]   rdata
);

  logic [3*W_VAL-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/poly_kernel_svm_classifier.sv -----
// Polynomial-kernel SVM classifier: config registers, sequencer, shared ALU.
// Classify work grows with n, the number of vectors in use, and is set by the
// shared multi-cycle multiplier (7 uses per vector at degree 3). One item at a
// time; s_axis_tready is high only when idle.
// Reset (rst, synchronous) restores register defaults and clears the vector
// count; table contents are undefined until loaded.
module poly_kernel_svm_classifier import pksvm_pkg::*; #(
  parameter int MAX_VECTORS = DEF_MAX_VECTORS,
  parameter int POLY_DEGREE = DEF_POLY_DEGREE,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // sv_index[7:0], sv_weight[47:8], sv_first[87:48], sv_second[127:88],
  // charge_density[166:128], track_length[205:167], zero pad
  input  logic [207:0]      s_axis_tdata,
  // kind[0]
  input  logic              s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // is_positive[0], decision_value[48:1], saturated[49], zero pad
  output logic [55:0]       m_axis_tdata,
  input  logic              cfg_we,
  input  logic [W_REGI-1:0] cfg_index,
  input  logic [W_VAL-1:0]  cfg_data
);

  localparam int AW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
  localparam int KW = (POLY_DEGREE > 1) ? $clog2(POLY_DEGREE) : 1;
  localparam logic [W_VAL-1:0] ONE = W_VAL'(1) << FRAC_BITS;
  localparam logic [KW-1:0] K_LAST = KW'(POLY_DEGREE - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_GAIN,
    S_F1_SUB, S_F1_MUL, S_F1_ADD, S_F1_X10,
    S_F2_SUB, S_F2_MUL, S_F2_ADD, S_F2_X10,
    S_VREAD, S_DOT1, S_DOT2, S_DOTADD, S_GAM, S_OFF, S_POW, S_WT, S_ACC,
    S_BIAS, S_OUT
  } state_t;

  state_t state;

  logic [W_VAL-1:0] gain, dqds_mean, len_mean, dqds_inv, len_inv, gamma, offset, rho;
  logic [W_CNT-1:0] vectors_in_use;
  logic [W_CNT-1:0] vidx;
  logic [KW-1:0]    kcnt;
  logic             pend;
  logic             sat_acc;
  logic [W_IN-1:0]  len_in;
  logic [W_SUM-1:0] tmp;
  logic [W_VAL-1:0] tmp2, f1, f2, base, pw;
  logic [W_SUM-1:0] acc;
  logic             out_pos, out_sat;
  logic [W_SUM-1:0] out_dec;

  logic [W_IDX-1:0] in_idx;
  logic [W_VAL-1:0] in_wt, in_first, in_second;
  logic [W_IN-1:0]  in_charge, in_len;
  logic             accept;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  logic             mul_state;
  logic [3*W_VAL-1:0] rd;
  logic             mem_we;
  logic             mem_re;

  logic signed [W_SUM-1:0] alu_a, alu_b;
  logic signed [W_SUM:0]   alu_sum;
  logic                    alu_wide, alu_use, alu_sat;
  logic [W_SUM-1:0]        alu_res;
  logic signed [W_SUM:0]   alu_hi, alu_lo;

  assign in_idx    = s_axis_tdata[7:0];
  assign in_wt     = s_axis_tdata[47:8];
  assign in_first  = s_axis_tdata[87:48];
  assign in_second = s_axis_tdata[127:88];
  assign in_charge = s_axis_tdata[166:128];
  assign in_len    = s_axis_tdata[205:167];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign mem_we = accept && (s_axis_tuser == KIND_LOAD) && (int'(in_idx) < MAX_VECTORS);
  assign mem_re = (state == S_VREAD);

  pksvm_sv_mem #(.DEPTH(MAX_VECTORS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(in_idx)),
    .wdata ({in_second, in_first, in_wt}),
    .re    (mem_re),
    .raddr (AW'(vidx)),
    .rdata (rd)
  );

  pksvm_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  // multiplier operand select
  always_comb begin
    mreq.a    = tmp[W_VAL-1:0];
    mreq.b    = gain;
    mreq.wide = 1'b0;
    mul_state = 1'b1;
    unique case (state)
      S_GAIN:   mreq.b = gain;
      S_F1_MUL: mreq.b = dqds_inv;
      S_F2_MUL: mreq.b = len_inv;
      S_DOT1:   begin mreq.a = rd[2*W_VAL-1:W_VAL];   mreq.b = f1; end
      S_DOT2:   begin mreq.a = rd[3*W_VAL-1:2*W_VAL]; mreq.b = f2; end
      S_GAM:    mreq.b = gamma;
      S_POW:    begin mreq.a = pw; mreq.b = base; end
      S_WT:     begin mreq.a = rd[W_VAL-1:0]; mreq.b = pw; mreq.wide = 1'b1; end
      default:  mul_state = 1'b0;
    endcase
    mreq.start = mul_state && !pend;
  end

  // shared saturating adder
  always_comb begin
    alu_a    = $signed(tmp);
    alu_b    = '0;
    alu_wide = 1'b0;
    alu_use  = 1'b1;
    unique case (state)
      S_F1_SUB: alu_b = -sx_val(dqds_mean);
      S_F2_SUB: begin
        alu_a = $signed(W_SUM'(len_in));
        alu_b = -sx_val(len_mean);
      end
      S_F1_ADD, S_F2_ADD: alu_b = sx_val(ONE);
      S_F1_X10, S_F2_X10: begin
        alu_a = sx_val(tmp[W_VAL-1:0]) <<< 3;
        alu_b = sx_val(tmp[W_VAL-1:0]) <<< 1;
      end
      S_DOTADD: alu_b = sx_val(tmp2);
      S_OFF:    alu_b = sx_val(offset);
      S_ACC:    begin alu_a = $signed(acc); alu_b = $signed(tmp); alu_wide = 1'b1; end
      S_BIAS:   begin alu_a = $signed(acc); alu_b = sx_val(rho); alu_wide = 1'b1; end
      default:  alu_use = 1'b0;
    endcase
    alu_sum = (W_SUM+1)'(alu_a) + (W_SUM+1)'(alu_b);
    alu_hi  = alu_wide ? (W_SUM+1)'((W_SUM+1)'(1) <<< (W_SUM - 1)) - 1
                       : (W_SUM+1)'((W_SUM+1)'(1) <<< (W_VAL - 1)) - 1;
    alu_lo  = -alu_hi - 1;
    alu_sat = 1'b0;
    alu_res = alu_sum[W_SUM-1:0];
    if (alu_sum > alu_hi) begin
      alu_sat = 1'b1;
      alu_res = alu_hi[W_SUM-1:0];
    end else if (alu_sum < alu_lo) begin
      alu_sat = 1'b1;
      alu_res = alu_lo[W_SUM-1:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain      <= ONE;
      dqds_mean <= '0;
      len_mean  <= '0;
      dqds_inv  <= ONE;
      len_inv   <= ONE;
      gamma     <= ONE;
      offset    <= '0;
      rho       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN:      gain      <= cfg_data;
        REG_DQDS_MEAN: dqds_mean <= cfg_data;
        REG_LEN_MEAN:  len_mean  <= cfg_data;
        REG_DQDS_INV:  dqds_inv  <= cfg_data;
        REG_LEN_INV:   len_inv   <= cfg_data;
        REG_GAMMA:     gamma     <= cfg_data;
        REG_OFFSET:    offset    <= cfg_data;
        REG_RHO:       rho       <= cfg_data;
        default:       ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      vectors_in_use <= '0;
      pend           <= 1'b0;
      m_axis_tvalid  <= 1'b0;
      sat_acc        <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) m_axis_tvalid <= 1'b0;
      if (mreq.start) pend <= 1'b1;
      if (alu_use) sat_acc <= sat_acc | alu_sat;
      if (mrsp.done) begin
        pend    <= 1'b0;
        sat_acc <= sat_acc | mrsp.sat;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_axis_tuser == KIND_LOAD) begin
              if (mem_we) vectors_in_use <= W_CNT'(in_idx) + W_CNT'(1);
            end else begin
              tmp     <= W_SUM'(in_charge);
              len_in  <= in_len;
              sat_acc <= 1'b0;
              state   <= S_GAIN;
            end
          end
        end
        S_GAIN:   if (mrsp.done) begin tmp <= mrsp.res; state <= S_F1_SUB; end
        S_F1_SUB: begin tmp <= alu_res; state <= S_F1_MUL; end
        S_F1_MUL: if (mrsp.done) begin tmp <= mrsp.res; state <= S_F1_ADD; end
        S_F1_ADD: begin tmp <= alu_res; state <= S_F1_X10; end
        S_F1_X10: begin f1 <= alu_res[W_VAL-1:0]; state <= S_F2_SUB; end
        S_F2_SUB: begin tmp <= alu_res; state <= S_F2_MUL; end
        S_F2_MUL: if (mrsp.done) begin tmp <= mrsp.res; state <= S_F2_ADD; end
        S_F2_ADD: begin tmp <= alu_res; state <= S_F2_X10; end
        S_F2_X10: begin
          f2    <= alu_res[W_VAL-1:0];
          vidx  <= '0;
          acc   <= '0;
          state <= S_VREAD;
        end
        S_VREAD:  state <= (vidx == vectors_in_use) ? S_BIAS : S_DOT1;
        S_DOT1:   if (mrsp.done) begin tmp <= mrsp.res; state <= S_DOT2; end
        S_DOT2:   if (mrsp.done) begin tmp2 <= mrsp.res[W_VAL-1:0]; state <= S_DOTADD; end
        S_DOTADD: begin tmp <= alu_res; state <= S_GAM; end
        S_GAM:    if (mrsp.done) begin tmp <= mrsp.res; state <= S_OFF; end
        S_OFF: begin
          base  <= alu_res[W_VAL-1:0];
          pw    <= ONE;
          kcnt  <= '0;
          state <= S_POW;
        end
        S_POW: if (mrsp.done) begin
          pw   <= mrsp.res[W_VAL-1:0];
          kcnt <= kcnt + KW'(1);
          if (kcnt == K_LAST) state <= S_WT;
        end
        S_WT:  if (mrsp.done) begin tmp <= mrsp.res; state <= S_ACC; end
        S_ACC: begin
          acc   <= alu_res;
          vidx  <= vidx + W_CNT'(1);
          state <= S_VREAD;
        end
        S_BIAS: begin acc <= alu_res; state <= S_OUT; end
        S_OUT: begin
          // hold until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            out_dec       <= acc;
            out_pos       <= !acc[W_SUM-1] && (acc != '0);
            out_sat       <= sat_acc;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {6'b0, out_sat, out_dec, out_pos};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(vectors_in_use) <= MAX_VECTORS) else $error("vector count beyond table");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_VREAD) |-> vidx <= vectors_in_use) else $error("walk past count");
  a_out_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && m_axis_tvalid && !m_axis_tready) |=> state == S_OUT)
    else $error("result overwrote a pending beat");
  a_mul_done_expected: assert property (@(posedge clk) disable iff (rst)
    mrsp.done |-> pend) else $error("multiplier result with no request");

endmodule
